/* rtl/odpm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odpm_pkg
// Shared types, constants and tables of the ordered-dither palette mapper.
// ----------------------------------------------------------------------------
package odpm_pkg;

    localparam int PALETTE_ENTRIES_DEF = 16;
    localparam int INDEX_W  = 4;
    localparam int CHAN_W   = 8;
    localparam int PHASE_W  = 3;
    localparam int RGB_W    = 3 * CHAN_W;
    localparam int SQ_W     = 16;
    localparam int TARGET_W = 18;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_DITHER = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [INDEX_W-1:0] entry_index;
        logic [PHASE_W-1:0] column_phase;
        logic [PHASE_W-1:0] row_phase;
        logic [CHAN_W-1:0]  red_in;
        logic [CHAN_W-1:0]  green_in;
        logic [CHAN_W-1:0]  blue_in;
    } in_word_t;

    typedef struct packed {
        logic [INDEX_W-1:0] chosen_index;
        logic [CHAN_W-1:0]  red_out;
        logic [CHAN_W-1:0]  green_out;
        logic [CHAN_W-1:0]  blue_out;
    } out_word_t;

    typedef struct packed {
        logic                is_dither;
        logic [INDEX_W-1:0]  entry_index;
        logic [TARGET_W-1:0] target;
        logic [RGB_W-1:0]    rgb;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_EMIT
    } back_state_t;

    typedef logic [5:0] bayer_t;

    localparam bayer_t BAYER [8][8] = '{
        '{6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63},
        '{6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31},
        '{6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55},
        '{6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23},
        '{6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61},
        '{6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29},
        '{6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53},
        '{6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21}
    };

    // dithered value at or above each edge moves up one of five levels
    localparam logic [CHAN_W-1:0] LEVEL_EDGE [4] = '{8'd32, 8'd96, 8'd160, 8'd224};

    // squares of the levels 0, 63, 127, 191, 255
    localparam logic [SQ_W-1:0] LEVEL_SQ [5] =
        '{16'd0, 16'd3969, 16'd16129, 16'd36481, 16'd65025};

endpackage

/* rtl/odpm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odpm_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module odpm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/odpm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odpm_front
// Classifies incoming words and reduces a pixel to its dithered target sum.
// ----------------------------------------------------------------------------
module odpm_front (
    input  odpm_pkg::in_word_t item,
    output odpm_pkg::cmd_t     cmd
);
    import odpm_pkg::*;

    function automatic logic [SQ_W-1:0] level_square(input logic [CHAN_W-1:0] c,
                                                     input bayer_t m);
        logic [17:0]       vsum;
        logic [17:0]       vpos;
        logic [9:0]        dq;
        logic [CHAN_W-1:0] d;
        logic [2:0]        q;
        vsum = {2'b00, c, 8'h00} + ({12'd0, m} + 18'd1) * 18'd255;
        vpos = vsum - 18'd8160;
        dq   = vpos[17:8];
        if (vsum < 18'd8160)
        begin
            d = '0;
        end
        else if (dq > 10'd255)
        begin
            d = '1;
        end
        else
        begin
            d = dq[7:0];
        end
        q = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (d >= LEVEL_EDGE[k])
            begin
                q = 3'(k + 1);
            end
        end
        return LEVEL_SQ[q];
    endfunction

    bayer_t          m;
    logic [SQ_W-1:0] sq_r;
    logic [SQ_W-1:0] sq_g;
    logic [SQ_W-1:0] sq_b;

    always_comb
    begin
        m    = BAYER[item.column_phase][item.row_phase];
        sq_r = level_square(item.red_in, m);
        sq_g = level_square(item.green_in, m);
        sq_b = level_square(item.blue_in, m);
        cmd.is_dither   = (item.opcode == OP_DITHER);
        cmd.entry_index = item.entry_index;
        cmd.target      = TARGET_W'(sq_r) + TARGET_W'(sq_g) + TARGET_W'(sq_b);
        cmd.rgb         = {item.red_in, item.green_in, item.blue_in};
    end

endmodule

/* rtl/odpm_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odpm_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module odpm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  odpm_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output odpm_pkg::cmd_t rd_data,
    output logic           empty
);
    import odpm_pkg::*;

    cmd_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                do_wr;
    logic                do_rd;

    assign full    = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/odpm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odpm_back
// Executes palette writes and scans the palette for the nearest entry.
// ----------------------------------------------------------------------------
module odpm_back #(
    parameter int PALETTE_ENTRIES = odpm_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  odpm_pkg::cmd_t      cmd,
    input  logic                cmd_valid,
    output logic                cmd_pop,
    output odpm_pkg::out_word_t result,
    output logic                empty,
    input  logic                pop
);
    import odpm_pkg::*;

    // entries past the writable range stay zero; one of them stands for all
    localparam int WRITABLE    = 2 ** INDEX_W;
    localparam int STORE_DEPTH = (PALETTE_ENTRIES < WRITABLE) ? PALETTE_ENTRIES : WRITABLE;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int SCAN_LEN    = (PALETTE_ENTRIES > WRITABLE) ? WRITABLE + 1 : PALETTE_ENTRIES;
    localparam int SCAN_W      = $clog2(SCAN_LEN);

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [SCAN_W-1:0]   scan_cnt_reg;
    logic [TARGET_W-1:0] target_reg;
    logic [STORE_DEPTH-1:0] valid_reg;

    logic                p1_vld_reg;
    logic                p1_last_reg;
    logic                p1_ok_reg;
    logic [SCAN_W-1:0]   p1_idx_reg;

    logic                p2_vld_reg;
    logic                p2_last_reg;
    logic [SCAN_W-1:0]   p2_idx_reg;
    logic [TARGET_W-1:0] p2_sum_reg;
    logic [RGB_W-1:0]    p2_rgb_reg;

    logic [TARGET_W-1:0] best_diff_reg;
    logic [SCAN_W-1:0]   best_idx_reg;
    logic [RGB_W-1:0]    best_rgb_reg;

    logic                out_vld_reg;
    out_word_t           out_word_reg;

    logic                ram_we;
    logic                ram_re;
    logic [STORE_AW-1:0] waddr;
    logic [STORE_AW-1:0] raddr;
    logic [RGB_W-1:0]    rdata;
    logic                wr_in_range;
    logic                rd_in_range;
    logic                scan_last;
    logic                load_pixel;
    logic                out_free;
    logic                emit;
    logic [RGB_W-1:0]    p1_rgb;
    logic [SQ_W-1:0]     sq_r;
    logic [SQ_W-1:0]     sq_g;
    logic [SQ_W-1:0]     sq_b;
    logic [TARGET_W-1:0] diff;
    logic                take;

    assign waddr       = cmd.entry_index[STORE_AW-1:0];
    assign raddr       = scan_cnt_reg[STORE_AW-1:0];
    assign wr_in_range = ({1'b0, cmd.entry_index} < (INDEX_W + 1)'(STORE_DEPTH));
    assign rd_in_range = ({1'b0, scan_cnt_reg} < (SCAN_W + 1)'(STORE_DEPTH));
    assign scan_last   = (scan_cnt_reg == SCAN_W'(SCAN_LEN - 1));
    assign out_free    = !out_vld_reg || pop;

    odpm_ram #(
        .WIDTH (RGB_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (cmd.rgb),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd.is_dither)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (p2_vld_reg && p2_last_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop    = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        load_pixel = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_pop    = cmd_valid;
                ram_we     = cmd_valid && !cmd.is_dither && wr_in_range;
                load_pixel = cmd_valid && cmd.is_dither;
            end
            ST_SCAN:
            begin
                ram_re = 1'b1;
            end
            ST_WAIT:
            begin
                ram_re = 1'b0;
            end
            ST_EMIT:
            begin
                emit = out_free;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        p1_rgb = p1_ok_reg ? rdata : '0;
        sq_r   = SQ_W'(p1_rgb[23:16]) * SQ_W'(p1_rgb[23:16]);
        sq_g   = SQ_W'(p1_rgb[15:8]) * SQ_W'(p1_rgb[15:8]);
        sq_b   = SQ_W'(p1_rgb[7:0]) * SQ_W'(p1_rgb[7:0]);
        diff   = (p2_sum_reg >= target_reg) ? p2_sum_reg - target_reg
                                            : target_reg - p2_sum_reg;
        take   = p2_vld_reg && ((p2_idx_reg == '0) || (diff < best_diff_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            valid_reg    <= '0;
            p1_vld_reg   <= 1'b0;
            p1_last_reg  <= 1'b0;
            p1_ok_reg    <= 1'b0;
            p2_vld_reg   <= 1'b0;
            p2_last_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_pixel)
            begin
                scan_cnt_reg <= '0;
            end
            else if (ram_re)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            if (ram_we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            p1_vld_reg  <= ram_re;
            p1_last_reg <= ram_re && scan_last;
            p1_ok_reg   <= ram_re && rd_in_range && valid_reg[raddr];
            p2_vld_reg  <= p1_vld_reg;
            p2_last_reg <= p1_last_reg;
            if (emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_pixel)
        begin
            target_reg <= cmd.target;
        end
        p1_idx_reg <= scan_cnt_reg;
        p2_idx_reg <= p1_idx_reg;
        p2_rgb_reg <= p1_rgb;
        p2_sum_reg <= TARGET_W'(sq_r) + TARGET_W'(sq_g) + TARGET_W'(sq_b);
        if (take)
        begin
            best_diff_reg <= diff;
            best_idx_reg  <= p2_idx_reg;
            best_rgb_reg  <= p2_rgb_reg;
        end
        if (emit)
        begin
            out_word_reg.chosen_index <= INDEX_W'(best_idx_reg);
            out_word_reg.red_out      <= best_rgb_reg[23:16];
            out_word_reg.green_out    <= best_rgb_reg[15:8];
            out_word_reg.blue_out     <= best_rgb_reg[7:0];
        end
    end

    assign result = out_word_reg;
    assign empty  = !out_vld_reg;

endmodule

/* rtl/ordered_dither_palette_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_dither_palette_map
// Bayer-dithers RGB pixels and maps them to the nearest palette entry.
// ----------------------------------------------------------------------------
// A palette write word is popped by the back end while idle and gives no result.
// A pixel word is popped while idle; the back end then scans SCAN_LEN entries,
// where SCAN_LEN is PALETTE_ENTRIES when it is at most 16 and 17 otherwise
// (entries above 15 cannot be written and stay zero, so one of them stands for
// the rest), waits for the last read to leave the pipeline and then emits the result.
// The scan reads one entry a cycle from the single read port of the palette RAM.
// The front end dithers and queues up to two words while the back end works,
// and the back end goes on while one result waits to be popped.
module ordered_dither_palette_map #(
    parameter int PALETTE_ENTRIES = odpm_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  odpm_pkg::in_word_t  item,
    output logic                empty,
    input  logic                pop,
    output odpm_pkg::out_word_t result
);
    import odpm_pkg::*;

    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic queue_empty;
    logic cmd_pop;

    odpm_front u_front (
        .item (item),
        .cmd  (front_cmd)
    );

    odpm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_cmd),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (queue_cmd),
        .empty   (queue_empty)
    );

    odpm_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (queue_cmd),
        .cmd_valid (!queue_empty),
        .cmd_pop   (cmd_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

/* rtl/odpm_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odpm_check
// Port-level checks of the palette mapper, bound to the top level.
// ----------------------------------------------------------------------------
module odpm_check #(
    parameter int PALETTE_ENTRIES = odpm_pkg::PALETTE_ENTRIES_DEF
) (
    input logic                clk,
    input logic                rst_n,
    input logic                push,
    input logic                full,
    input odpm_pkg::in_word_t  item,
    input logic                empty,
    input logic                pop,
    input odpm_pkg::out_word_t result
);
    import odpm_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed before pop");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((PALETTE_ENTRIES >= 16) || (int'(result.chosen_index) < PALETTE_ENTRIES)))
        else $error("chosen index beyond palette");

    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> (empty && !full))
        else $error("not empty and ready after reset");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !$isunknown(result))
        else $error("unknown bits in result word");

endmodule

bind ordered_dither_palette_map odpm_check #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
) u_check (.*);

/* verif/tb_ordered_dither_palette_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_dither_palette_map
// Palette writes and Bayer-dithered pixels are pushed with random push and pop
// gaps. The nearest palette entry for every pixel is worked out alongside the
// block and compared field by field with each popped result word.
// ----------------------------------------------------------------------------
module tb_ordered_dither_palette_map;

    import odpm_pkg::*;

    localparam int NUM_ENTRIES = 16;

    localparam bit [5:0] OFFSET_MAT [8][8] = '{
        '{6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63},
        '{6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31},
        '{6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55},
        '{6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23},
        '{6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61},
        '{6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29},
        '{6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53},
        '{6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21}
    };

    localparam bit [7:0] LEVELS [5] = '{8'd0, 8'd63, 8'd127, 8'd191, 8'd255};

    class palette_scoreboard;
        bit [7:0]  pal_r [NUM_ENTRIES];
        bit [7:0]  pal_g [NUM_ENTRIES];
        bit [7:0]  pal_b [NUM_ENTRIES];
        out_word_t nearest_q [$];
        int        errors;

        function new();
            errors = 0;
            foreach (pal_r[i])
            begin
                pal_r[i] = '0;
                pal_g[i] = '0;
                pal_b[i] = '0;
            end
        endfunction

        function int unsigned dithered_level(int unsigned c, int unsigned m);
            int          v;
            int unsigned d;
            int unsigned q;
            v = int'(256 * c) + int'(255 * (m + 1)) - 8160;
            if (v < 0)
            begin
                d = 0;
            end
            else
            begin
                d = v / 256;
                if (d > 255)
                    d = 255;
            end
            q = (8 * d + 255) / 510;
            return (q * 255) / 4;
        endfunction

        function void note_word(in_word_t w);
            int unsigned m;
            int unsigned lr;
            int unsigned lg;
            int unsigned lb;
            int unsigned target;
            int unsigned s;
            int unsigned diff;
            int unsigned best_diff;
            int          best;
            out_word_t   exp_word;
            if (w.opcode == OP_WRITE)
            begin
                if (int'(w.entry_index) < NUM_ENTRIES)
                begin
                    pal_r[w.entry_index] = w.red_in;
                    pal_g[w.entry_index] = w.green_in;
                    pal_b[w.entry_index] = w.blue_in;
                end
                return;
            end
            m = OFFSET_MAT[w.column_phase][w.row_phase];
            lr = dithered_level(w.red_in, m);
            lg = dithered_level(w.green_in, m);
            lb = dithered_level(w.blue_in, m);
            target = lr * lr + lg * lg + lb * lb;
            best = 0;
            best_diff = '1;
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                s = pal_r[i] * pal_r[i] + pal_g[i] * pal_g[i] + pal_b[i] * pal_b[i];
                diff = (s > target) ? s - target : target - s;
                if (i == 0 || diff < best_diff)
                begin
                    best_diff = diff;
                    best = i;
                end
            end
            exp_word.chosen_index = best[3:0];
            exp_word.red_out      = pal_r[best];
            exp_word.green_out    = pal_g[best];
            exp_word.blue_out     = pal_b[best];
            nearest_q.push_back(exp_word);
        endfunction

        function void check_word(out_word_t got);
            out_word_t exp_word;
            if (nearest_q.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
                return;
            end
            exp_word = nearest_q.pop_front();
            if (got.chosen_index !== exp_word.chosen_index)
            begin
                $display("%0t: chosen_index expected %0d got %0d", $time,
                         exp_word.chosen_index, got.chosen_index);
                errors++;
            end
            if (got.red_out !== exp_word.red_out)
            begin
                $display("%0t: red_out expected %0d got %0d", $time,
                         exp_word.red_out, got.red_out);
                errors++;
            end
            if (got.green_out !== exp_word.green_out)
            begin
                $display("%0t: green_out expected %0d got %0d", $time,
                         exp_word.green_out, got.green_out);
                errors++;
            end
            if (got.blue_out !== exp_word.blue_out)
            begin
                $display("%0t: blue_out expected %0d got %0d", $time,
                         exp_word.blue_out, got.blue_out);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_word_t  item;
    logic      empty;
    logic      pop;
    out_word_t result;

    palette_scoreboard sb;
    int send_gap_pct;
    int recv_gap_pct;

    ordered_dither_palette_map i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic in_word_t make_word(logic op, int idx, int col, int row,
                                           int r, int g, int b);
        in_word_t w;
        w.opcode       = op;
        w.entry_index  = idx[3:0];
        w.column_phase = col[2:0];
        w.row_phase    = row[2:0];
        w.red_in       = r[7:0];
        w.green_in     = g[7:0];
        w.blue_in      = b[7:0];
        return w;
    endfunction

    function automatic int random_chan();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0: return 0;
            1: return 255;
            2: return LEVELS[$urandom_range(4)];
            default: return $urandom_range(255);
        endcase
    endfunction

    function automatic in_word_t random_word();
        logic op;
        op = ($urandom_range(99) < 15) ? OP_WRITE : OP_DITHER;
        return make_word(op, $urandom_range(15), $urandom_range(7), $urandom_range(7),
                         random_chan(), random_chan(), random_chan());
    endfunction

    // call just after a falling edge; returns just after a falling edge
    task automatic drive_word(in_word_t w);
        while ($urandom_range(99) < send_gap_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        item = w;
        push = 1'b1;
        do
            @(posedge clk);
        while (full);
        sb.note_word(w);
        @(negedge clk);
    endtask

    task automatic drain_pending();
        push = 1'b0;
        while (sb.nearest_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_directed();
        // empty palette: everything maps to entry zero
        drive_word(make_word(OP_DITHER, 15, 7, 7, 255, 255, 255));
        drive_word(make_word(OP_DITHER, 0, 0, 0, 0, 0, 0));
        drive_word(make_word(OP_WRITE, 0, 7, 7, 0, 0, 0));
        drive_word(make_word(OP_WRITE, 15, 5, 2, 255, 255, 255));
        // equal square sums: lower index wins
        drive_word(make_word(OP_WRITE, 3, 0, 0, 63, 0, 0));
        drive_word(make_word(OP_WRITE, 9, 0, 0, 0, 63, 0));
        drive_word(make_word(OP_WRITE, 6, 0, 0, 127, 127, 127));
        drive_word(make_word(OP_WRITE, 12, 3, 4, 191, 0, 191));
        drive_word(make_word(OP_DITHER, 15, 0, 0, 63, 0, 0));
        drive_word(make_word(OP_DITHER, 0, 7, 7, 0, 63, 0));
        drive_word(make_word(OP_DITHER, 10, 0, 7, 255, 255, 255));
        drive_word(make_word(OP_DITHER, 5, 7, 0, 0, 0, 0));
        drive_word(make_word(OP_DITHER, 1, 3, 3, 128, 128, 128));
        drive_word(make_word(OP_DITHER, 2, 1, 6, 32, 96, 160));
        drive_word(make_word(OP_DITHER, 8, 6, 1, 224, 31, 95));
        drive_word(make_word(OP_DITHER, 4, 4, 4, 200, 10, 170));
        // overwrite an entry and reuse it
        drive_word(make_word(OP_WRITE, 6, 0, 0, 0, 0, 1));
        drive_word(make_word(OP_DITHER, 7, 2, 5, 127, 127, 127));
        drive_word(make_word(OP_DITHER, 11, 5, 3, 1, 254, 17));
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        send_gap_pct = 0;
        recv_gap_pct = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_gap_pct = 8;
        recv_gap_pct = 55;
        run_directed();
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_gap_pct = 8;
                    recv_gap_pct = 55;
                end
                1:
                begin
                    send_gap_pct = 55;
                    recv_gap_pct = 8;
                end
                default:
                begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
            endcase
            for (int n = 0; n < 362; n++)
            begin
                drive_word(random_word());
                if (n == 180)
                    drain_pending();
            end
        end
        push = 1'b0;

        for (int k = 0; k < 20000 && sb.nearest_q.size() != 0; k++)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.nearest_q.size() != 0)
        begin
            $display("%0t: %0d result words never arrived", $time, sb.nearest_q.size());
            sb.errors++;
        end
        if (sb.errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            pop = ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_word(result);
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/odpm_pkg.sv
rtl/odpm_ram.sv
rtl/odpm_front.sv
rtl/odpm_queue.sv
rtl/odpm_back.sv
rtl/ordered_dither_palette_map.sv
rtl/odpm_check.sv
verif/tb_ordered_dither_palette_map.sv
